// File: rtl/core/brm_pkg.sv
// Shared types and constants for the bidirectional run merge block.
// No dependencies; every other file of the block but brm_ram imports this package.
package brm_pkg;

	// Field widths fixed by the interface
	localparam int OPC_W = 2;
	localparam int VAL_W = 32;
	localparam int POS_W = 10;
	localparam int CFG_W = 11;
	localparam int CFG_IDX_W = 1;

	// Input opcodes
	localparam logic [OPC_W-1:0] OPC_LOAD    = 2'd0;
	localparam logic [OPC_W-1:0] OPC_STEP    = 2'd1;
	localparam logic [OPC_W-1:0] OPC_RESTART = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT  = 1'b1;

	// Classified item kinds carried through the queue
	typedef enum logic [1:0] {
		KIND_LOAD,
		KIND_STEP,
		KIND_RESTART
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [VAL_W-1:0]  value;
	} item_t;

	// Queue head as seen by the back end
	typedef struct packed {
		logic  valid;
		item_t item;
	} q_head_t;

	typedef struct packed {
		logic              front_valid;
		logic [POS_W-1:0]  front_position;
		logic [VAL_W-1:0]  front_value;
		logic              back_valid;
		logic [POS_W-1:0]  back_position;
		logic [VAL_W-1:0]  back_value;
		logic              merge_done;
	} result_t;

endpackage

// File: rtl/core/brm_ram.sv
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module brm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: rtl/core/brm_front.sv
// Front end: accepts input transactions, classifies the opcode and queues them.
// Depends on brm_pkg.
module brm_front
	import brm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_stall,
	input  logic [OPC_W-1:0] opcode,
	input  logic [VAL_W-1:0] element_value,
	output q_head_t          head,
	input  logic             pop
);

	localparam logic [1:0] QDEPTH = 2'd2;

	item_t      slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       keep;
	kind_t      kind;
	logic       push;
	logic       do_pop;

	// Classify the opcode; the unused code is accepted and dropped
	always_comb begin
		keep = 1'b1;
		kind = KIND_STEP;
		unique case (opcode)
			OPC_LOAD:    kind = KIND_LOAD;
			OPC_STEP:    kind = KIND_STEP;
			OPC_RESTART: kind = KIND_RESTART;
			default:     keep = 1'b0;
		endcase
	end

	assign item_stall = (cnt_q == QDEPTH);
	assign push       = item_valid && !item_stall && keep;
	assign do_pop     = pop && (cnt_q != 2'd0);

	assign head.valid = (cnt_q != 2'd0);
	assign head.item  = slot_q[rp_q];

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= '{kind: kind, value: element_value};
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (do_pop) begin
				rp_q <= !rp_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

endmodule

// File: rtl/core/brm_engine.sv
// Back end: holds the configuration, the element store and the merge pointers,
// executes queued items and drives the result register. Depends on brm_pkg, brm_ram.
module brm_engine
	import brm_pkg::*;
#(
	parameter int STORE_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  q_head_t              head,
	output logic                 pop,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result
);

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam logic [CW-1:0] ONE = CW'(1);
	localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_EMIT
	} state_t;

	state_t state_q;

	logic [CFG_W-1:0] total_q;
	logic [CFG_W-1:0] left_q;
	logic [CW-1:0]    tot_q, lft_q, rgt_q, fq_q, bq_q;
	logic [CW-1:0]    tot_c, lft_c;
	logic [CW:0]      tot_inc;

	logic [CW-1:0] lp_q;
	logic [CW-1:0] fl_q, fr_q, bl_q, br_q, fe_q, be_q;

	logic          fla, fra, bla, bra;
	logic [CW-1:0] f_rsum, b_lsum, b_rsum;
	logic [AW-1:0] f_li, f_ri, b_li, b_ri;
	logic [VAL_W-1:0] fl_d, fr_d, bl_d, br_d;
	logic          front_go, back_go, f_take_l, b_take_l;
	logic [CW-1:0] fe_nx, be_nx;
	logic          emit_ok;
	logic          ram_we;
	result_t       emit_r;

	// Clamp the registers to the store depth and the total
	always_comb begin
		tot_c = (32'(total_q) > 32'(STORE_DEPTH)) ? DEPTH_C : CW'(total_q);
		lft_c = (32'(left_q) > 32'(tot_c)) ? tot_c : CW'(left_q);
		tot_inc = {1'b0, tot_q} + {1'b0, ONE};
	end

	// Availability of each run per side and store addresses
	always_comb begin
		fla    = fl_q < lft_q;
		fra    = fr_q < rgt_q;
		bla    = bl_q < lft_q;
		bra    = br_q < rgt_q;
		f_rsum = lft_q + fr_q;
		b_lsum = lft_q - ONE - bl_q;
		b_rsum = tot_q - ONE - br_q;
		f_li   = fla ? AW'(fl_q) : '0;
		f_ri   = fra ? AW'(f_rsum) : '0;
		b_li   = bla ? AW'(b_lsum) : '0;
		b_ri   = bra ? AW'(b_rsum) : '0;
	end

	assign pop    = (state_q == S_IDLE) && head.valid;
	assign ram_we = pop && (head.item.kind == KIND_LOAD) && (lp_q < DEPTH_C);

	// Two copies of the store: one for the front side, one for the back side
	brm_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_front_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (AW'(lp_q)),
		.wdata   (head.item.value),
		.raddr_a (f_li),
		.raddr_b (f_ri),
		.rdata_a (fl_d),
		.rdata_b (fr_d)
	);

	brm_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_back_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (AW'(lp_q)),
		.wdata   (head.item.value),
		.raddr_a (b_li),
		.raddr_b (b_ri),
		.rdata_a (bl_d),
		.rdata_b (br_d)
	);

	// Pick the element for each side; ties go left in front, right in back
	always_comb begin
		front_go = (fe_q < fq_q) && (fla || fra);
		back_go  = (be_q < bq_q) && (bla || bra);
		f_take_l = fla && (!fra || ($signed(fl_d) <= $signed(fr_d)));
		b_take_l = bla && (!bra || ($signed(bl_d) > $signed(br_d)));
		fe_nx    = fe_q + CW'(front_go);
		be_nx    = be_q + CW'(back_go);
		emit_ok  = !result_valid || !result_stall;
	end

	// Assemble the step result; an idle side reports zeros
	always_comb begin
		emit_r = '0;
		if (front_go) begin
			emit_r.front_valid    = 1'b1;
			emit_r.front_position = POS_W'(fe_q);
			emit_r.front_value    = f_take_l ? fl_d : fr_d;
		end
		if (back_go) begin
			emit_r.back_valid    = 1'b1;
			emit_r.back_position = POS_W'(tot_q - ONE - be_q);
			emit_r.back_value    = b_take_l ? bl_d : br_d;
		end
		emit_r.merge_done = (fe_nx >= fq_q) && (be_nx >= bq_q);
	end

	// Sequencer, pointers, configuration and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			total_q      <= '0;
			left_q       <= '0;
			tot_q        <= '0;
			lft_q        <= '0;
			rgt_q        <= '0;
			fq_q         <= '0;
			bq_q         <= '0;
			lp_q         <= '0;
			fl_q         <= '0;
			fr_q         <= '0;
			bl_q         <= '0;
			br_q         <= '0;
			fe_q         <= '0;
			be_q         <= '0;
			result_valid <= 1'b0;
			result       <= '0;
		end else begin
			if (cfg_write_en) begin
				unique case (cfg_index)
					REG_TOTAL: total_q <= cfg_data;
					REG_LEFT:  left_q  <= cfg_data;
					default:   ;
				endcase
			end

			// Derived counts are registered from the clamped registers; the side quotas from the registered total
			tot_q <= tot_c;
			lft_q <= lft_c;
			rgt_q <= tot_c - lft_c;
			fq_q  <= tot_inc[CW:1];
			bq_q  <= tot_q >> 1;

			// Raise valid on an emit, drop it once the result is taken
			if ((state_q == S_EMIT) && emit_ok) begin
				result_valid <= 1'b1;
			end else if (result_valid && !result_stall) begin
				result_valid <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (head.valid) begin
						unique case (head.item.kind)
							KIND_LOAD: begin
								if (lp_q < DEPTH_C) begin
									lp_q <= lp_q + ONE;
								end
							end
							KIND_STEP: begin
								state_q <= S_READ;
							end
							KIND_RESTART: begin
								lp_q <= '0;
								fl_q <= '0;
								fr_q <= '0;
								bl_q <= '0;
								br_q <= '0;
								fe_q <= '0;
								be_q <= '0;
							end
							default: ;
						endcase
					end
				end
				S_READ: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (emit_ok) begin
						result <= emit_r;
						if (front_go) begin
							if (f_take_l) begin
								fl_q <= fl_q + ONE;
							end else begin
								fr_q <= fr_q + ONE;
							end
						end
						if (back_go) begin
							if (b_take_l) begin
								bl_q <= bl_q + ONE;
							end else begin
								br_q <= br_q + ONE;
							end
						end
						fe_q    <= fe_nx;
						be_q    <= be_nx;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// File: rtl/core/bidirectional_run_merge.sv
// Top level of the bidirectional run merge: front queue plus merge engine.
// Depends on brm_pkg, brm_front, brm_engine (and brm_ram below it).
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------------
//   item     | item_valid / item_stall    | opcode, element_value
//   result   | result_valid / result_stall| front_*, back_*, merge_done
//   config   | cfg_write_en               | cfg_index, cfg_data
//
// A load or restart is handled in the idle state; a merge step goes through issue,
// the registered store read, and compare and emit, which holds while the result stalls.
// A two-entry queue takes items while the engine or the result register is busy.
// Reset clears pointers, counts and registers; the store itself is not cleared.
// A stalled result holds in the output register; the engine waits on it to emit.
module bidirectional_run_merge
	import brm_pkg::*;
#(
	parameter int STORE_DEPTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic [OPC_W-1:0]     opcode,
	input  logic signed [VAL_W-1:0] element_value,
	input  logic                 cfg_write_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 front_valid,
	output logic [POS_W-1:0]     front_position,
	output logic signed [VAL_W-1:0] front_value,
	output logic                 back_valid,
	output logic [POS_W-1:0]     back_position,
	output logic signed [VAL_W-1:0] back_value,
	output logic                 merge_done
);

	q_head_t head;
	logic    pop;
	result_t result;

	brm_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.opcode        (opcode),
		.element_value (element_value),
		.head          (head),
		.pop           (pop)
	);

	brm_engine #(.STORE_DEPTH(STORE_DEPTH)) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	// Unpack the result register onto the ports
	assign front_valid    = result.front_valid;
	assign front_position = result.front_position;
	assign front_value    = result.front_value;
	assign back_valid     = result.back_valid;
	assign back_position  = result.back_position;
	assign back_value     = result.back_value;
	assign merge_done     = result.merge_done;

endmodule

// File: rtl/core/brm_checker.sv
// Port-level checks for the bidirectional run merge, bound to the top level.
// Depends on brm_pkg and bidirectional_run_merge.
module brm_checker
	import brm_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 result_valid,
	input logic                 result_stall,
	input logic                 front_valid,
	input logic [POS_W-1:0]     front_position,
	input logic [VAL_W-1:0]     front_value,
	input logic                 back_valid,
	input logic [POS_W-1:0]     back_position,
	input logic [VAL_W-1:0]     back_value,
	input logic                 merge_done
);

	// Hold a stalled result transaction
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(front_value)
			&& $stable(back_value) && $stable(merge_done))
		else $error("stalled result changed");

	// An idle front side reports zeros
	a_front_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !front_valid |-> front_position == '0 && front_value == '0)
		else $error("idle front side not zero");

	// An idle back side reports zeros
	a_back_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !back_valid |-> back_position == '0 && back_value == '0)
		else $error("idle back side not zero");

	// No result right after reset
	a_reset_empty: assert property (@(posedge clk)
		!$past(arst_n) |-> !result_valid)
		else $error("result present after reset");

endmodule

bind bidirectional_run_merge brm_checker u_brm_checker (.*);

// File: bench/tb_bidirectional_run_merge.sv
// Testbench for bidirectional_run_merge: a merge model predicts every step result,
// which is checked field by field against the block's output transactions.
// Depends on brm_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb_bidirectional_run_merge;
	import brm_pkg::*;

	localparam int DEPTH = 256;
	localparam logic [OPC_W-1:0] OPC_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 10;
	localparam int MIX_ITEMS = 100;
	localparam int MAX_REPORTS = 10;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    item_valid = 1'b0;
	logic                    item_stall;
	logic [OPC_W-1:0]        opcode = OPC_LOAD;
	logic signed [VAL_W-1:0] element_value = '0;
	logic                    cfg_write_en = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = REG_TOTAL;
	logic [CFG_W-1:0]        cfg_data = '0;
	logic                    result_valid;
	logic                    result_stall = 1'b0;
	logic                    front_valid;
	logic [POS_W-1:0]        front_position;
	logic signed [VAL_W-1:0] front_value;
	logic                    back_valid;
	logic [POS_W-1:0]        back_position;
	logic signed [VAL_W-1:0] back_value;
	logic                    merge_done;

	bidirectional_run_merge #(
		.STORE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.opcode(opcode),
		.element_value(element_value),
		.cfg_write_en(cfg_write_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.front_valid(front_valid),
		.front_position(front_position),
		.front_value(front_value),
		.back_valid(back_valid),
		.back_position(back_position),
		.back_value(back_value),
		.merge_done(merge_done)
	);

	always #2 clk = ~clk;

	// Merge model state: store image, consumed counts per side and run, registers
	logic [VAL_W-1:0] store_image [DEPTH];
	int unsigned load_ptr = 0;
	int unsigned stored_len = 0;
	int unsigned front_left = 0, front_right = 0, back_left = 0, back_right = 0;
	int unsigned front_sent = 0, back_sent = 0;
	int unsigned total_reg = 0, left_reg = 0;
	result_t     merge_outputs_due [$];
	result_t     due;

	int send_idle_pct = 0;
	int stall_pct = 0;
	int counted_items = 0;
	int checked_results = 0;
	int mismatch_count = 0;

	function automatic int unsigned clamped_total();
		return (total_reg > DEPTH) ? DEPTH : total_reg;
	endfunction

	// Advance the merge model by one accepted transaction
	task automatic merge_model_apply(input logic [OPC_W-1:0] op, input logic [VAL_W-1:0] v);
		int unsigned tot, lft, rgt, fq, bq, li, ri;
		logic la, ra;
		result_t r;
		r = '0;
		case (op)
			OPC_LOAD: begin
				// drop loads once the store is full
				if (load_ptr < DEPTH) begin
					store_image[load_ptr] = v;
					load_ptr++;
					if (load_ptr > stored_len)
						stored_len = load_ptr;
				end
			end
			OPC_RESTART: begin
				load_ptr = 0;
				front_left = 0;
				front_right = 0;
				back_left = 0;
				back_right = 0;
				front_sent = 0;
				back_sent = 0;
			end
			OPC_STEP: begin
				tot = clamped_total();
				lft = (left_reg > tot) ? tot : left_reg;
				rgt = tot - lft;
				fq = (tot + 1) / 2;
				bq = tot / 2;
				// front side: smallest head, left wins ties
				if (front_sent < fq) begin
					la = front_left < lft;
					ra = front_right < rgt;
					if (la || ra) begin
						li = front_left;
						ri = lft + front_right;
						if (la && (!ra ||
								$signed(store_image[li]) <= $signed(store_image[ri]))) begin
							r.front_value = store_image[li];
							front_left++;
						end else begin
							r.front_value = store_image[ri];
							front_right++;
						end
						r.front_valid = 1'b1;
						r.front_position = POS_W'(front_sent);
						front_sent++;
					end
				end
				// back side: largest tail, right wins ties
				if (back_sent < bq) begin
					la = back_left < lft;
					ra = back_right < rgt;
					if (la || ra) begin
						li = lft - 1 - back_left;
						ri = tot - 1 - back_right;
						if (la && (!ra ||
								$signed(store_image[li]) > $signed(store_image[ri]))) begin
							r.back_value = store_image[li];
							back_left++;
						end else begin
							r.back_value = store_image[ri];
							back_right++;
						end
						r.back_valid = 1'b1;
						r.back_position = POS_W'(tot - 1 - back_sent);
						back_sent++;
					end
				end
				r.merge_done = (front_sent >= fq) && (back_sent >= bq);
				merge_outputs_due.push_back(r);
			end
			default: ;
		endcase
	endtask

	task automatic set_mix(input int idle_pct, input int hold_pct);
		send_idle_pct = idle_pct;
		stall_pct = hold_pct;
	endtask

	// Present one item, hold it until accepted, then update the model
	task automatic send_item(input logic [OPC_W-1:0] op, input logic [VAL_W-1:0] v);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		opcode <= op;
		element_value <= v;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		if (op == OPC_STEP || op == OPC_RESTART || (op == OPC_LOAD && load_ptr < DEPTH))
			counted_items++;
		merge_model_apply(op, v);
	endtask

	// Hold off the sender until every predicted result is out, then let the engine settle
	task automatic wait_drained();
		item_valid <= 1'b0;
		@(posedge clk);
		while (merge_outputs_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
		cfg_write_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(data);
		@(posedge clk);
		cfg_write_en <= 1'b0;
		@(posedge clk);
		if (idx == REG_TOTAL)
			total_reg = data & 32'h7FF;
		else
			left_reg = data & 32'h7FF;
	endtask

	// Load an ascending run; narrow runs sit near zero and repeat values often
	task automatic load_sorted_run(input int unsigned len, input bit narrow);
		longint acc;
		int unsigned stride;
		if (narrow) begin
			stride = 3;
			acc = longint'($urandom_range(0, 40)) - 20;
		end else begin
			stride = 32'hFFFF_FFFF / (len + 1);
			acc = longint'(-2147483647) - 1 + longint'($urandom_range(0, stride));
		end
		for (int unsigned i = 0; i < len; i++) begin
			send_item(OPC_LOAD, acc[VAL_W-1:0]);
			if ($urandom_range(3) != 0)
				acc += longint'($urandom_range(0, stride));
		end
	endtask

	// Extremes, ties, empty configuration, unused opcode, step after done
	task automatic test_short_cases();
		logic [VAL_W-1:0] runs [9];
		runs = '{32'h8000_0000, 32'hFFFF_FFFB, 32'd3, 32'd3, 32'h7FFF_FFFF,
			32'h8000_0000, 32'd3, 32'd3, 32'd100};
		set_mix(0, 0);
		send_item(OPC_STEP, '1);
		send_item(OPC_UNUSED, 32'hFFFF_FFFF);
		foreach (runs[i])
			send_item(OPC_LOAD, runs[i]);
		wait_drained();
		write_reg(REG_TOTAL, 9);
		write_reg(REG_LEFT, 5);
		repeat (6) send_item(OPC_STEP, '0);
		wait_drained();
	endtask

	// Consumed counts survive register writes; left above total clamps
	task automatic test_register_change_mid_merge();
		send_item(OPC_RESTART, '1);
		repeat (2) send_item(OPC_STEP, '0);
		wait_drained();
		write_reg(REG_LEFT, DEPTH);
		repeat (3) send_item(OPC_STEP, '0);
		wait_drained();
		write_reg(REG_TOTAL, 4);
		write_reg(REG_LEFT, 2);
		repeat (2) send_item(OPC_STEP, '0);
		wait_drained();
	endtask

	// Whole store in use, loads past the end dropped
	task automatic test_full_store();
		int unsigned lft;
		set_mix(17, 17);
		lft = $urandom_range(0, DEPTH);
		write_reg(REG_TOTAL, DEPTH);
		write_reg(REG_LEFT, lft);
		send_item(OPC_RESTART, $urandom());
		load_sorted_run(lft, 1'b0);
		load_sorted_run(DEPTH - lft, 1'b0);
		repeat (2) send_item(OPC_LOAD, $urandom());
		repeat (DEPTH / 2 + 1) send_item(OPC_STEP, $urandom());
		wait_drained();
	endtask

	// One merge with random sizes and content, sprinkled with noise and broken sequences
	task automatic run_merge_session();
		int unsigned tot, lcfg, lft, steps, pick;
		bit narrow;
		pick = $urandom_range(99);
		if (pick < 70)
			tot = $urandom_range(0, 24);
		else if (pick < 95)
			tot = $urandom_range(25, 100);
		else
			tot = $urandom_range(101, 300);
		pick = $urandom_range(99);
		if (pick < 80)
			lcfg = $urandom_range(0, tot);
		else if (pick < 90)
			lcfg = $urandom_range(1) ? 0 : tot;
		else
			lcfg = $urandom_range(tot, DEPTH);
		lft = (lcfg > tot) ? tot : lcfg;
		narrow = $urandom_range(1);
		write_reg(REG_TOTAL, tot);
		write_reg(REG_LEFT, lcfg);
		send_item(OPC_RESTART, $urandom());
		load_sorted_run(lft, narrow);
		load_sorted_run(tot - lft, narrow);
		steps = (tot + 1) / 2 + $urandom_range(0, 2);
		for (int unsigned i = 0; i < steps; i++) begin
			pick = $urandom_range(99);
			if (pick < 5)
				send_item(OPC_UNUSED, $urandom());
			else if (pick < 9)
				send_item(OPC_LOAD, $urandom());
			else if (pick < 11)
				send_item(OPC_RESTART, $urandom());
			// occasionally retune a register halfway through the merge
			if (i == steps / 2 && $urandom_range(4) == 0) begin
				wait_drained();
				if ($urandom_range(1))
					write_reg(REG_LEFT, $urandom_range(0, tot + 2));
				else
					write_reg(REG_TOTAL, $urandom_range(0, stored_len));
			end
			send_item(OPC_STEP, $urandom());
		end
		wait_drained();
	endtask

	task automatic test_random_merges();
		int mix_start;
		int idle_mix [4];
		int hold_mix [4];
		idle_mix = '{0, 77, 0, 17};
		hold_mix = '{0, 0, 77, 17};
		for (int m = 0; m < 4; m++) begin
			set_mix(idle_mix[m], hold_mix[m]);
			mix_start = counted_items;
			while (counted_items - mix_start < MIX_ITEMS)
				run_merge_session();
		end
	endtask

	// Check each result transaction against the oldest prediction; randomize the stall
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			checked_results++;
			if (merge_outputs_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display({"%0t: result with none predicted: ",
						"front %0b/%0d/%0d back %0b/%0d/%0d done %0b"},
						$time, front_valid, front_position, front_value,
						back_valid, back_position, back_value, merge_done);
			end else begin
				due = merge_outputs_due.pop_front();
				if (front_valid !== due.front_valid ||
						front_position !== due.front_position ||
						front_value !== due.front_value ||
						back_valid !== due.back_valid ||
						back_position !== due.back_position ||
						back_value !== due.back_value ||
						merge_done !== due.merge_done) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display({"%0t: expected front %0b/%0d/%0d back %0b/%0d/%0d ",
							"done %0b, got front %0b/%0d/%0d back %0b/%0d/%0d done %0b"},
							$time, due.front_valid, due.front_position,
							$signed(due.front_value),
							due.back_valid, due.back_position, $signed(due.back_value),
							due.merge_done, front_valid, front_position, front_value,
							back_valid, back_position, back_value, merge_done);
				end
			end
		end
		result_stall <= ($urandom_range(99) < stall_pct);
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_short_cases();
		test_register_change_mid_merge();
		test_full_store();
		test_random_merges();
		wait_drained();
		if (merge_outputs_due.size() != 0) begin
			$display("%0d predicted results never arrived", merge_outputs_due.size());
			mismatch_count += merge_outputs_due.size();
		end
		$display("Checked %0d merge results from %0d counted transactions, %0d mismatches.",
			checked_results, counted_items, mismatch_count);
		$display({"Covered totals from 0 to full store, clamped left counts, ",
			"mid-merge register writes and four idle mixes."});
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Watchdog against a hung handshake
	initial begin
		#2_000_000;
		$display("Run did not complete in the allotted time");
		$display("FAILED: results differ");
		$finish;
	end

endmodule
